// ----- rtl/core/mdcp_pkg.sv -----
// ----------------------------------------------------------------------------
// mdcp_pkg
// shared widths, register indexes and constants of the cruise drive controller
// ----------------------------------------------------------------------------
package mdcp_pkg;

    localparam int DRIVE_BITS  = 12;
    localparam int SAMPLE_BITS = 10;

    localparam int SPEED_BITS  = 6;
    localparam int PROP_BITS   = 12;
    localparam int INTEG_BITS  = 8;
    localparam int BASE_BITS   = 12;
    localparam int THR_BITS    = 10;
    localparam int SUM_BITS    = 16;
    localparam int ERR_BITS    = SPEED_BITS + 1;

    localparam int ACC_W       = 26;
    localparam int DIFF_W      = (SAMPLE_BITS > THR_BITS ? SAMPLE_BITS : THR_BITS) + 1;
    localparam int REM_W       = THR_BITS + 1;
    localparam int CNT_MAX     = DRIVE_BITS > PROP_BITS ? DRIVE_BITS : PROP_BITS;
    localparam int CNT_W       = $clog2(CNT_MAX + 1);

    localparam int IN_W        = ((2 + 2 * SPEED_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((DRIVE_BITS + 3 + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DRIVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_SPD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THR_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THR_SPAN   = 3'd6;

    localparam logic [PROP_BITS-1:0]  PROP_GAIN_RST  = 12'd400;
    localparam logic [INTEG_BITS-1:0] INTEG_GAIN_RST = 8'd5;
    localparam logic [BASE_BITS-1:0]  BASE_DRIVE_RST = 12'd2000;
    localparam logic [SPEED_BITS-1:0] START_SPD_RST  = 6'd5;
    localparam logic [SPEED_BITS-1:0] UPPER_SPD_RST  = 6'd32;
    localparam logic [THR_BITS-1:0]   THR_OFFSET_RST = 10'd130;
    localparam logic [THR_BITS-1:0]   THR_SPAN_RST   = 10'd528;

    localparam logic signed [ACC_W-1:0] SUM_LIMIT  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] DRIVE_MAX  = ACC_W'((1 << DRIVE_BITS) - 1);

    typedef logic [DRIVE_BITS-1:0] drive_t;

endpackage

// ----- rtl/core/motor_drive_cruise_pi.sv -----
// ----------------------------------------------------------------------------
// motor_drive_cruise_pi
// electric bike motor drive controller with throttle mapping and pi cruise
// ----------------------------------------------------------------------------
// sequence: brake, start-up, hold and end-of-range throttle ticks go straight to
//   the result; other throttle ticks run the restoring divider, and a pi tick runs
//   the integrator step, 12 + 8 shift-add steps and the clamp
// flow: the next transaction is taken only once the result is issued to the
//   output register; the issued result waits there until it is taken
// reset: synchronous aresetn clears state and handshakes, loads register defaults
// ----------------------------------------------------------------------------
module motor_drive_cruise_pi
    import mdcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // brake_on, ride_enabled, cruise_target, speed_now, throttle_sample
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // drive_level, drive_written, brake_lamp, cruise_cancel
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INTEG = 3'd1;
    localparam logic [2:0] ST_MULP  = 3'd2;
    localparam logic [2:0] ST_MULI  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DRV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // configuration registers
    logic [PROP_BITS-1:0]  prop_gain_reg;
    logic [INTEG_BITS-1:0] integ_gain_reg;
    logic [BASE_BITS-1:0]  base_drive_reg;
    logic [SPEED_BITS-1:0] start_speed_reg;
    logic [SPEED_BITS-1:0] upper_speed_reg;
    logic [THR_BITS-1:0]   thr_offset_reg;
    logic [THR_BITS-1:0]   thr_span_reg;

    // controller state
    logic signed [SUM_BITS-1:0] error_sum_reg;
    drive_t                     last_drive_reg;

    // sequencer
    logic [2:0]                 state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    mcand_reg;
    logic [PROP_BITS-1:0]       mplier_reg;
    logic [REM_W-1:0]           rem_reg;
    drive_t                     quot_reg;
    logic signed [ERR_BITS-1:0] err_reg;
    logic                       win_reg;

    // pending result
    drive_t                     res_drive_reg;
    logic                       res_written_reg;
    logic                       res_lamp_reg;
    logic                       res_cancel_reg;

    // output register
    logic [OUT_W-1:0]           m_tdata_reg;
    logic                       m_tvalid_reg;

    // input fields
    logic                       in_brake;
    logic                       in_enabled;
    logic [SPEED_BITS-1:0]      in_target;
    logic [SPEED_BITS-1:0]      in_speed;
    logic [SAMPLE_BITS-1:0]     in_sample;

    logic                       in_accept;
    logic signed [DIFF_W-1:0]   diff;
    logic [THR_BITS-1:0]        span_eff;
    logic [SPEED_BITS+2:0]      speed_x5;
    logic [SPEED_BITS+2:0]      target_x6;
    logic [SPEED_BITS+2:0]      target_x4;
    drive_t                     base_sat;

    // shared adder
    logic signed [ACC_W-1:0]    add_a;
    logic signed [ACC_W-1:0]    add_b;
    logic signed [ACC_W-1:0]    add_sum;
    logic signed [SUM_BITS-1:0] sum_sat;

    assign in_brake   = s_tdata[0];
    assign in_enabled = s_tdata[1];
    assign in_target  = s_tdata[2 +: SPEED_BITS];
    assign in_speed   = s_tdata[2 + SPEED_BITS +: SPEED_BITS];
    assign in_sample  = s_tdata[2 + 2 * SPEED_BITS +: SAMPLE_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign diff      = signed'(DIFF_W'(in_sample)) - signed'(DIFF_W'(thr_offset_reg));
    assign span_eff  = (thr_span_reg == '0) ? THR_BITS'(1) : thr_span_reg;
    assign speed_x5  = (SPEED_BITS + 3)'(in_speed) * (SPEED_BITS + 3)'(5);
    assign target_x6 = (SPEED_BITS + 3)'(in_target) * (SPEED_BITS + 3)'(6);
    assign target_x4 = (SPEED_BITS + 3)'(in_target) * (SPEED_BITS + 3)'(4);
    assign base_sat  = (ACC_W'(base_drive_reg) > DRIVE_MAX) ? DRIVE_BITS'(DRIVE_MAX)
                                                            : DRIVE_BITS'(base_drive_reg);

    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            ST_INTEG: begin
                add_a = ACC_W'(error_sum_reg);
                add_b = ACC_W'(err_reg);
            end
            ST_MULP, ST_MULI: begin
                add_a = acc_reg;
                add_b = mplier_reg[0] ? mcand_reg : '0;
            end
            ST_DIV: begin
                add_a = signed'(ACC_W'({rem_reg[REM_W-2:0], 1'b0}));
                add_b = -signed'(ACC_W'(span_eff));
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    always_comb begin
        priority if (add_sum > SUM_LIMIT) begin
            sum_sat = SUM_BITS'(SUM_LIMIT);
        end else if (add_sum < -SUM_LIMIT) begin
            sum_sat = SUM_BITS'(-SUM_LIMIT);
        end else begin
            sum_sat = add_sum[SUM_BITS-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            base_drive_reg  <= BASE_DRIVE_RST;
            start_speed_reg <= START_SPD_RST;
            upper_speed_reg <= UPPER_SPD_RST;
            thr_offset_reg  <= THR_OFFSET_RST;
            thr_span_reg    <= THR_SPAN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg   <= cfg_data[PROP_BITS-1:0];
                REG_INTEG_GAIN: integ_gain_reg  <= cfg_data[INTEG_BITS-1:0];
                REG_BASE_DRIVE: base_drive_reg  <= cfg_data[BASE_BITS-1:0];
                REG_START_SPD:  start_speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_UPPER_SPD:  upper_speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_THR_OFFSET: thr_offset_reg  <= cfg_data[THR_BITS-1:0];
                REG_THR_SPAN:   thr_span_reg    <= cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            error_sum_reg   <= '0;
            last_drive_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
            cnt_reg         <= '0;
            res_written_reg <= 1'b0;
            res_lamp_reg    <= 1'b0;
            res_cancel_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        res_written_reg <= 1'b1;
                        res_lamp_reg    <= 1'b0;
                        res_cancel_reg  <= 1'b0;
                        priority if (in_brake || !in_enabled) begin
                            res_drive_reg  <= '0;
                            res_lamp_reg   <= 1'b1;
                            res_cancel_reg <= 1'b1;
                            state_reg      <= ST_DONE;
                        end else if (in_target == '0) begin
                            priority if (diff <= 0) begin
                                res_drive_reg <= '0;
                                state_reg     <= ST_DONE;
                            end else if (diff >= signed'(DIFF_W'(span_eff))) begin
                                res_drive_reg <= DRIVE_BITS'(DRIVE_MAX);
                                state_reg     <= ST_DONE;
                            end else begin
                                rem_reg   <= REM_W'(diff);
                                quot_reg  <= '0;
                                cnt_reg   <= CNT_W'(DRIVE_BITS);
                                state_reg <= ST_DIV;
                            end
                        end else if (in_speed < start_speed_reg) begin
                            res_drive_reg <= base_sat;
                            state_reg     <= ST_DONE;
                        end else if (in_speed < upper_speed_reg) begin
                            err_reg   <= signed'(ERR_BITS'(in_target)) -
                                         signed'(ERR_BITS'(in_speed));
                            win_reg   <= (speed_x5 <= target_x6) && (speed_x5 >= target_x4);
                            state_reg <= ST_INTEG;
                        end else begin
                            res_drive_reg   <= last_drive_reg;
                            res_written_reg <= 1'b0;
                            state_reg       <= ST_DONE;
                        end
                    end
                end
                ST_INTEG: begin
                    error_sum_reg <= win_reg ? sum_sat : '0;
                    acc_reg       <= signed'(ACC_W'(base_drive_reg));
                    mcand_reg     <= ACC_W'(err_reg);
                    mplier_reg    <= prop_gain_reg;
                    cnt_reg       <= CNT_W'(PROP_BITS);
                    state_reg     <= ST_MULP;
                end
                ST_MULP: begin
                    acc_reg <= add_sum;
                    if (cnt_reg == CNT_W'(1)) begin
                        mcand_reg  <= ACC_W'(error_sum_reg);
                        mplier_reg <= PROP_BITS'(integ_gain_reg);
                        cnt_reg    <= CNT_W'(INTEG_BITS);
                        state_reg  <= ST_MULI;
                    end else begin
                        mcand_reg  <= mcand_reg <<< 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_MULI: begin
                    acc_reg    <= add_sum;
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_DRV;
                    end
                end
                ST_DRV: begin
                    priority if (acc_reg < 0) begin
                        res_drive_reg <= '0;
                    end else if (acc_reg > DRIVE_MAX) begin
                        res_drive_reg <= DRIVE_BITS'(DRIVE_MAX);
                    end else begin
                        res_drive_reg <= acc_reg[DRIVE_BITS-1:0];
                    end
                    state_reg <= ST_DONE;
                end
                ST_DIV: begin
                    // restoring step, remainder stays below the span
                    if (add_sum >= 0) begin
                        rem_reg  <= add_sum[REM_W-1:0];
                        quot_reg <= {quot_reg[DRIVE_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg  <= {rem_reg[REM_W-2:0], 1'b0};
                        quot_reg <= {quot_reg[DRIVE_BITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        res_drive_reg <= {quot_reg[DRIVE_BITS-2:0], add_sum >= 0};
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg    <= OUT_W'({res_cancel_reg, res_lamp_reg,
                                                  res_written_reg, res_drive_reg});
                        m_tvalid_reg   <= 1'b1;
                        last_drive_reg <= res_drive_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- verif/tb_mdcp_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_mdcp_pkg
// transaction layouts and tick kinds shared by the cruise drive testbench
// ----------------------------------------------------------------------------
package tb_mdcp_pkg;

    import mdcp_pkg::*;

    // input transaction, brake_on in the lowest bit
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] throttle_sample;
        logic [SPEED_BITS-1:0]  speed_now;
        logic [SPEED_BITS-1:0]  cruise_target;
        logic                   ride_enabled;
        logic                   brake_on;
    } tick_in_t;

    localparam int RES_PAD = OUT_W - DRIVE_BITS - 3;

    // result transaction, drive_level in the lowest bits
    typedef struct packed {
        logic [RES_PAD-1:0] pad;
        logic               cruise_cancel;
        logic               brake_lamp;
        logic               drive_written;
        drive_t             drive_level;
    } drive_res_t;

    typedef enum logic [2:0] {
        TICK_BRAKE,
        TICK_MANUAL,
        TICK_STARTUP,
        TICK_PI,
        TICK_HOLD
    } tick_mode_t;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

endpackage

// ----- verif/drive_checker.sv -----
// ----------------------------------------------------------------------------
// drive_checker
// watches the tick, result and register channels of the cruise drive block,
// predicts each drive result from its own copy of registers, integrator and
// drive, and compares every result field by field in arrival order
// ----------------------------------------------------------------------------
module drive_checker
    import mdcp_pkg::*;
    import tb_mdcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // brake_on, ride_enabled, cruise_target, speed_now, throttle_sample
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // drive_level, drive_written, brake_lamp, cruise_cancel
    input  logic [OUT_W-1:0]      m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    n_checked,
    output int                    n_brake,
    output int                    n_manual,
    output int                    n_startup,
    output int                    n_pi,
    output int                    n_hold,
    output int                    sum_peak,
    output int                    sum_floor
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [PROP_BITS-1:0]  prop_gain;
    logic [INTEG_BITS-1:0] integ_gain;
    logic [BASE_BITS-1:0]  base_drive;
    logic [SPEED_BITS-1:0] start_spd;
    logic [SPEED_BITS-1:0] upper_spd;
    logic [THR_BITS-1:0]   thr_offset;
    logic [THR_BITS-1:0]   thr_span;

    int         integ_sum;
    drive_t     drive_now;

    drive_res_t expected_drive_q[$];
    drive_res_t want;
    drive_res_t got;
    tick_mode_t mode;

    function automatic drive_t clamp_drive(input longint v);
        if (v < 0)
            return '0;
        if (v > DRIVE_MAX)
            return drive_t'(DRIVE_MAX);
        return drive_t'(v);
    endfunction

    function automatic drive_res_t predict_drive(input tick_in_t t, output tick_mode_t kind);
        drive_res_t r;
        longint     span;
        longint     num;
        longint     tgt;
        longint     spd;
        longint     err;
        longint     acc;
        r = '0;
        r.drive_written = 1'b1;
        tgt = longint'(t.cruise_target);
        spd = longint'(t.speed_now);
        if (t.brake_on || !t.ride_enabled) begin
            kind = TICK_BRAKE;
            drive_now = '0;
            r.brake_lamp = 1'b1;
            r.cruise_cancel = 1'b1;
        end else if (tgt == 0) begin
            kind = TICK_MANUAL;
            span = (thr_span == '0) ? 64'sd1 : longint'(thr_span);
            num = (longint'(t.throttle_sample) - longint'(thr_offset)) *
                  (longint'(1) << DRIVE_BITS);
            drive_now = clamp_drive(num / span);
        end else if (spd < longint'(start_spd)) begin
            kind = TICK_STARTUP;
            drive_now = clamp_drive(longint'(base_drive));
        end else if (spd < longint'(upper_spd)) begin
            kind = TICK_PI;
            err = tgt - spd;
            // integrator runs only within +-20% of the target
            if (5 * spd <= 6 * tgt && 5 * spd >= 4 * tgt) begin
                acc = longint'(integ_sum) + err;
                if (acc > SUM_LIMIT)
                    acc = SUM_LIMIT;
                if (acc < -SUM_LIMIT)
                    acc = -SUM_LIMIT;
                integ_sum = int'(acc);
            end else begin
                integ_sum = 0;
            end
            drive_now = clamp_drive(longint'(prop_gain) * err + longint'(base_drive) +
                                    longint'(integ_gain) * longint'(integ_sum));
        end else begin
            kind = TICK_HOLD;
            r.drive_written = 1'b0;
        end
        r.drive_level = drive_now;
        return r;
    endfunction

    function automatic void check_field(input string what, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain  = PROP_GAIN_RST;
            integ_gain = INTEG_GAIN_RST;
            base_drive = BASE_DRIVE_RST;
            start_spd  = START_SPD_RST;
            upper_spd  = UPPER_SPD_RST;
            thr_offset = THR_OFFSET_RST;
            thr_span   = THR_SPAN_RST;
            integ_sum  = 0;
            drive_now  = '0;
            expected_drive_q.delete();
            errors    = 0;
            pending   = 0;
            n_checked = 0;
            n_brake   = 0;
            n_manual  = 0;
            n_startup = 0;
            n_pi      = 0;
            n_hold    = 0;
            sum_peak  = 0;
            sum_floor = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:  prop_gain  = cfg_data[PROP_BITS-1:0];
                    REG_INTEG_GAIN: integ_gain = cfg_data[INTEG_BITS-1:0];
                    REG_BASE_DRIVE: base_drive = cfg_data[BASE_BITS-1:0];
                    REG_START_SPD:  start_spd  = cfg_data[SPEED_BITS-1:0];
                    REG_UPPER_SPD:  upper_spd  = cfg_data[SPEED_BITS-1:0];
                    REG_THR_OFFSET: thr_offset = cfg_data[THR_BITS-1:0];
                    REG_THR_SPAN:   thr_span   = cfg_data[THR_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = drive_res_t'(m_tdata);
                if (expected_drive_q.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction with no tick pending, %s %h",
                             $time, "expected none, actual", m_tdata);
                end else begin
                    want = expected_drive_q.pop_front();
                    check_field("drive_level", want.drive_level, got.drive_level);
                    check_field("drive_written", want.drive_written, got.drive_written);
                    check_field("brake_lamp", want.brake_lamp, got.brake_lamp);
                    check_field("cruise_cancel", want.cruise_cancel, got.cruise_cancel);
                    check_field("padding", want.pad, got.pad);
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_drive_q.push_back(predict_drive(tick_in_t'(s_tdata), mode));
                unique case (mode)
                    TICK_BRAKE:   n_brake++;
                    TICK_MANUAL:  n_manual++;
                    TICK_STARTUP: n_startup++;
                    TICK_PI:      n_pi++;
                    default:      n_hold++;
                endcase
                if (integ_sum > sum_peak)
                    sum_peak = integ_sum;
                if (integ_sum < sum_floor)
                    sum_floor = integ_sum;
            end
            pending = expected_drive_q.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the cruise drive block: directed ticks at reset defaults and
// register extremes, long integrator runs and random ride sequences
// under random idling and one long output stall; a checker beside the block
// compares every result
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mdcp_pkg::*;
    import tb_mdcp_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int TIMEOUT_NS   = 8_000_000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int n_checked;
    int n_brake;
    int n_manual;
    int n_startup;
    int n_pi;
    int n_hold;
    int sum_peak;
    int sum_floor;

    int ticks_sent    = 0;
    int cfg_settings  = 1;
    int thr_offset_now = THR_OFFSET_RST;
    int thr_span_now   = THR_SPAN_RST;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;
    bit hold_armed    = 1'b0;

    motor_drive_cruise_pi u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drive_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .n_checked (n_checked),
        .n_brake   (n_brake),
        .n_manual  (n_manual),
        .n_startup (n_startup),
        .n_pi      (n_pi),
        .n_hold    (n_hold),
        .sum_peak  (sum_peak),
        .sum_floor (sum_floor)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic tick_in_t mk_tick(input int brake, input int en, input int tgt,
                                         input int spd, input int thr);
        tick_in_t t;
        t.brake_on        = brake[0];
        t.ride_enabled    = en[0];
        t.cruise_target   = tgt[SPEED_BITS-1:0];
        t.speed_now       = spd[SPEED_BITS-1:0];
        t.throttle_sample = thr[SAMPLE_BITS-1:0];
        return t;
    endfunction

    function automatic tick_in_t rand_tick();
        tick_in_t t;
        int       sel;
        int       tgt;
        int       spd;
        int       delta;
        int       thr;
        t.brake_on        = ($urandom_range(0, 15) == 0);
        t.ride_enabled    = ($urandom_range(0, 15) != 0);
        t.cruise_target   = SPEED_BITS'($urandom());
        t.speed_now       = SPEED_BITS'($urandom());
        t.throttle_sample = SAMPLE_BITS'($urandom());
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            t.cruise_target = '0;
            if ($urandom_range(0, 1) == 1) begin
                thr = thr_offset_now + $urandom_range(0, thr_span_now + 4) - 2;
                if (thr < 0)
                    thr = 0;
                if (thr > (1 << SAMPLE_BITS) - 1)
                    thr = (1 << SAMPLE_BITS) - 1;
                t.throttle_sample = SAMPLE_BITS'(thr);
            end
        end else if (sel < 9) begin
            // speed close to the set speed, around the integrator window
            tgt = $urandom_range(1, 63);
            delta = $urandom_range(0, tgt / 4 + 2);
            if ($urandom_range(0, 1) == 1)
                delta = -delta;
            spd = tgt + delta;
            if (spd < 0)
                spd = 0;
            if (spd > 63)
                spd = 63;
            t.cruise_target = SPEED_BITS'(tgt);
            t.speed_now     = SPEED_BITS'(spd);
        end
        return t;
    endfunction

    task automatic send_tick(input tick_in_t t);
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        ticks_sent++;
        if (!tx_quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_tick(rand_tick());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] word);
        cfg_index <= idx;
        cfg_data  <= word;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] reg_word(input int value, input int bits,
                                                        input bit junk);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'(value);
        if (junk && bits < CFG_DATA_W)
            w = w | (CFG_DATA_W'($urandom()) << bits);
        return w;
    endfunction

    task automatic program_regs(input int p, input int i, input int b, input int st,
                                input int up, input int off, input int sp, input bit junk);
        write_reg(REG_PROP_GAIN,  reg_word(p,   PROP_BITS,  junk));
        write_reg(REG_INTEG_GAIN, reg_word(i,   INTEG_BITS, junk));
        write_reg(REG_BASE_DRIVE, reg_word(b,   BASE_BITS,  junk));
        write_reg(REG_START_SPD,  reg_word(st,  SPEED_BITS, junk));
        write_reg(REG_UPPER_SPD,  reg_word(up,  SPEED_BITS, junk));
        write_reg(REG_THR_OFFSET, reg_word(off, THR_BITS,   junk));
        write_reg(REG_THR_SPAN,   reg_word(sp,  THR_BITS,   junk));
        cfg_valid <= 1'b0;
        thr_offset_now = off;
        thr_span_now   = (sp == 0) ? 1 : sp;
        cfg_settings++;
    endtask

    task automatic random_regs();
        int p;
        int i;
        int b;
        int st;
        int up;
        p  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
        i  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
        b  = $urandom_range(0, 4095);
        st = $urandom_range(0, 20);
        up = $urandom_range(st, 63);
        program_regs(p, i, b, st, up, $urandom_range(0, 400), $urandom_range(1, 1023), 1'b1);
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin : rx_side
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_armed) begin
                hold_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults
        send_tick(mk_tick(1, 1, 20, 20, 1023));
        send_tick(mk_tick(0, 0, 20, 20, 0));
        send_tick(mk_tick(1, 0, 63, 63, 1023));
        send_tick(mk_tick(0, 1, 0, 0, 0));
        send_tick(mk_tick(0, 1, 0, 10, 130));
        send_tick(mk_tick(0, 1, 0, 0, 658));
        send_tick(mk_tick(0, 1, 0, 63, 1023));
        send_tick(mk_tick(0, 1, 0, 30, 400));
        send_tick(mk_tick(0, 1, 63, 0, 0));
        send_tick(mk_tick(0, 1, 20, 4, 0));
        send_tick(mk_tick(0, 1, 20, 20, 0));
        send_tick(mk_tick(0, 1, 20, 18, 0));
        send_tick(mk_tick(0, 1, 20, 16, 0));
        send_tick(mk_tick(0, 1, 20, 24, 0));
        send_tick(mk_tick(0, 1, 20, 15, 0));
        send_tick(mk_tick(0, 1, 20, 18, 0));
        send_tick(mk_tick(1, 1, 20, 18, 0));
        send_tick(mk_tick(0, 1, 20, 18, 0));
        send_tick(mk_tick(0, 1, 31, 32, 0));
        send_tick(mk_tick(0, 1, 1, 5, 0));
        send_tick(mk_tick(0, 1, 63, 31, 0));
        wait_drained();

        // all registers at their maximum
        program_regs(4095, 255, 4095, 63, 63, 1023, 1023, 1'b0);
        send_tick(mk_tick(0, 1, 0, 63, 1023));
        send_tick(mk_tick(0, 1, 63, 62, 0));
        send_tick(mk_tick(0, 1, 63, 63, 0));
        send_random(60);
        wait_drained();

        // all registers at zero, zero span
        write_reg(REG_UNUSED, reg_word(0, 0, 1'b1));
        program_regs(0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_tick(mk_tick(0, 1, 0, 0, 1));
        send_tick(mk_tick(0, 1, 0, 0, 0));
        send_tick(mk_tick(0, 1, 5, 5, 0));
        send_random(60);
        wait_drained();

        // start speed above upper speed
        program_regs(300, 10, 1500, 40, 20, 100, 600, 1'b1);
        send_random(60);
        wait_drained();

        // long integrator runs on both sides of the target
        program_regs(1, 1, 0, 0, 63, 0, 1, 1'b0);
        tx_quiet = 1'b1;
        repeat (120) send_tick(mk_tick(0, 1, 63, 51, $urandom_range(0, 1023)));
        send_tick(mk_tick(0, 1, 20, 0, 0));
        repeat (120) send_tick(mk_tick(0, 1, 52, 62, $urandom_range(0, 1023)));
        tx_quiet = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            random_regs();
            if (ph == 1)
                hold_armed = 1'b1;
            if (ph == 4) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            send_random(80);
            wait_drained();
        end

        $display("summary: %0d results over %0d register settings", n_checked, cfg_settings);
        $display("summary: %0d brake, %0d throttle, %0d start-up, %0d pi, %0d hold ticks",
                 n_brake, n_manual, n_startup, n_pi, n_hold);
        $display("summary: integrator reached %0d and %0d, output held off once for %0d cycles",
                 sum_floor, sum_peak, LONG_HOLD);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d ticks sent and %0d results pending", ticks_sent, pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
